// ----- rtl/lsmd_pkg.sv -----
// Package for the lidar sector mean distance block.
// Shared widths, register indexes, sector codes and controller/datapath structs.
// No dependencies.
package lsmd_pkg;

	localparam int MAX_BEAMS_DEF = 1024;

	localparam int RANGE_W    = 16;
	localparam int START_W    = 16;
	localparam int STEP_W     = 12;
	localparam int MEAN_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// sector limits in centidegrees, all tests strict
	localparam int CENTER_LIM = 1500;
	localparam int SIDE_LIM   = 6000;

	localparam logic signed [START_W-1:0] START_RST = -16'sd18000;
	localparam logic [STEP_W-1:0]         STEP_RST  = 12'd100;
	localparam logic [RANGE_W-1:0]        STOP_RST  = 16'd1500;
	localparam logic [MEAN_W-1:0]         DFLT_RST  = 16'd15000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START = 2'd0,
		REG_STEP  = 2'd1,
		REG_STOP  = 2'd2,
		REG_DFLT  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SEC_LEFT   = 2'd0,
		SEC_RIGHT  = 2'd1,
		SEC_CENTER = 2'd2,
		SEC_NONE   = 2'd3
	} sector_t;

	typedef struct packed {
		logic    take;       // input transfer this cycle
		logic    mul;        // form beam index times step
		logic    acc;        // classify and accumulate
		logic    div_start;  // launch division of div_sel
		sector_t div_sel;
		logic    out_load;   // load result register, clear beam index, sums and counts
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/lsmd_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Quotient is assumed to fit in lsmd_pkg::MEAN_W bits. Depends on lsmd_pkg.
module lsmd_div #(
	parameter int SW = 27,
	parameter int CW = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SW-1:0]              num,
	input  logic [CW-1:0]              den,
	output logic                       done,
	output logic [lsmd_pkg::MEAN_W-1:0] quo
);

	localparam int QW  = lsmd_pkg::MEAN_W;
	localparam int DW  = CW + QW - 1;
	localparam int NW  = $clog2(QW);

	logic [SW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge = rem_q >= SW'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= {den, {(QW-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - SW'(den_q);
			den_q <= den_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/lsmd_dp.sv -----
// Datapath: configuration registers, beam angle, sector sums and counts,
// shared divider and result register. Depends on lsmd_pkg and lsmd_div.
module lsmd_dp #(
	parameter int MAX_BEAMS = lsmd_pkg::MAX_BEAMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [lsmd_pkg::RANGE_W-1:0]        s_tdata,
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	input  logic                                cfg_we,
	input  logic [lsmd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lsmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [3*lsmd_pkg::MEAN_W-1:0]       m_tdata,
	output logic                                m_tuser,
	input  lsmd_pkg::cmd_t                      cmd,
	output lsmd_pkg::sts_t                      sts
);

	localparam int RW = lsmd_pkg::RANGE_W;
	localparam int MW = lsmd_pkg::MEAN_W;
	localparam int IW = $clog2(MAX_BEAMS + 1);
	localparam int PW = IW + lsmd_pkg::STEP_W;
	localparam int AW = PW + 2;
	localparam int SW = RW + IW;

	localparam logic signed [AW-1:0] LIM_CP = AW'(lsmd_pkg::CENTER_LIM);
	localparam logic signed [AW-1:0] LIM_CN = AW'(-lsmd_pkg::CENTER_LIM);
	localparam logic signed [AW-1:0] LIM_SP = AW'(lsmd_pkg::SIDE_LIM);
	localparam logic signed [AW-1:0] LIM_SN = AW'(-lsmd_pkg::SIDE_LIM);

	logic signed [lsmd_pkg::START_W-1:0] start_q;
	logic [lsmd_pkg::STEP_W-1:0]         step_q;
	logic [RW-1:0]                       stop_q;
	logic [MW-1:0]                       dflt_q;

	logic [RW-1:0]        range_s1;
	logic                 noret_s1;
	logic                 last_s1;
	logic [PW-1:0]        prod_s2;
	logic                 ok_s2;

	logic [IW-1:0]        idx_q;
	logic [SW-1:0]        sum_q [3];
	logic [IW-1:0]        cnt_q [3];
	logic [MW-1:0]        mean_q [3];
	logic                 close_q;

	logic                 out_vld_q;
	logic [3*MW-1:0]      out_data_q;
	logic                 out_user_q;

	logic signed [AW-1:0] angle;
	lsmd_pkg::sector_t    sec;
	logic                 beam_use;
	logic                 div_done;
	logic [MW-1:0]        div_quo;
	logic [MW-1:0]        mean_out [3];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= lsmd_pkg::START_RST;
			step_q  <= lsmd_pkg::STEP_RST;
			stop_q  <= lsmd_pkg::STOP_RST;
			dflt_q  <= lsmd_pkg::DFLT_RST;
		end else if (cfg_we) begin
			case (lsmd_pkg::cfg_idx_t'(cfg_idx))
				lsmd_pkg::REG_START: start_q <= cfg_wdata;
				lsmd_pkg::REG_STEP:  step_q  <= cfg_wdata[lsmd_pkg::STEP_W-1:0];
				lsmd_pkg::REG_STOP:  stop_q  <= cfg_wdata;
				lsmd_pkg::REG_DFLT:  dflt_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// beam capture and angle product
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			range_s1 <= s_tdata;
			noret_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
		if (cmd.mul) begin
			prod_s2 <= PW'(idx_q) * PW'(step_q);
			ok_s2   <= idx_q < IW'(MAX_BEAMS);
		end
	end

	assign angle    = signed'({2'b00, prod_s2}) + AW'(start_q);
	assign beam_use = cmd.acc && ok_s2 && !noret_s1;

	always_comb begin
		if (angle > LIM_CN && angle < LIM_CP)
			sec = lsmd_pkg::SEC_CENTER;
		else if (angle > LIM_CP && angle < LIM_SP)
			sec = lsmd_pkg::SEC_RIGHT;
		else if (angle < LIM_CN && angle > LIM_SN)
			sec = lsmd_pkg::SEC_LEFT;
		else
			sec = lsmd_pkg::SEC_NONE;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			close_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (cmd.out_load) begin
			idx_q <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (cmd.acc) begin
			if (ok_s2)
				idx_q <= idx_q + 1'b1;
			if (beam_use && range_s1 < stop_q)
				close_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				if (beam_use && sec == lsmd_pkg::sector_t'(i)) begin
					sum_q[i] <= sum_q[i] + SW'(range_s1);
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	lsmd_div #(
		.SW(SW),
		.CW(IW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (sum_q[cmd.div_sel]),
		.den    (cnt_q[cmd.div_sel]),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (div_done && cmd.div_sel == lsmd_pkg::sector_t'(i))
				mean_q[i] <= div_quo;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			mean_out[i] = (cnt_q[i] == '0) ? dflt_q : mean_q[i];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.out_load)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {mean_out[lsmd_pkg::SEC_CENTER], mean_out[lsmd_pkg::SEC_RIGHT],
				mean_out[lsmd_pkg::SEC_LEFT]};
			out_user_q <= close_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	assign sts.last     = last_s1;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_vld_q || m_tready;

endmodule

// ----- rtl/lsmd_ctrl.sv -----
// Controller: sequences beam accumulation, the three per-sector divisions
// and the result load. Depends on lsmd_pkg.
module lsmd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  lsmd_pkg::sts_t  sts,
	output lsmd_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_MUL      = 6'b000010,
		ST_ACC      = 6'b000100,
		ST_DIV_GO   = 6'b001000,
		ST_DIV_WAIT = 6'b010000,
		ST_OUT      = 6'b100000
	} state_t;

	state_t            st_q;
	state_t            st_d;
	lsmd_pkg::sector_t sel_q;
	lsmd_pkg::sector_t sel_d;
	logic              take;

	// the accumulate cycle can already take the next beam unless it ends the scan
	assign s_tready = (st_q == ST_IDLE) || (st_q == ST_ACC && !sts.last);
	assign take     = s_tvalid && s_tready;

	always_comb begin
		st_d  = st_q;
		sel_d = sel_q;
		case (st_q)
			ST_IDLE: begin
				if (take)
					st_d = ST_MUL;
			end
			ST_MUL: st_d = ST_ACC;
			ST_ACC: begin
				if (sts.last) begin
					st_d  = ST_DIV_GO;
					sel_d = lsmd_pkg::SEC_LEFT;
				end else if (take) begin
					st_d = ST_MUL;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_DIV_GO: st_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					case (sel_q)
						lsmd_pkg::SEC_LEFT: begin
							sel_d = lsmd_pkg::SEC_RIGHT;
							st_d  = ST_DIV_GO;
						end
						lsmd_pkg::SEC_RIGHT: begin
							sel_d = lsmd_pkg::SEC_CENTER;
							st_d  = ST_DIV_GO;
						end
						default: st_d = ST_OUT;
					endcase
				end
			end
			ST_OUT: begin
				if (sts.out_free)
					st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			sel_q <= lsmd_pkg::SEC_LEFT;
		end else begin
			st_q  <= st_d;
			sel_q <= sel_d;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.mul       = (st_q == ST_MUL);
		cmd.acc       = (st_q == ST_ACC);
		cmd.div_start = (st_q == ST_DIV_GO);
		cmd.div_sel   = sel_q;
		cmd.out_load  = (st_q == ST_OUT) && sts.out_free;
	end

	a_take_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> st_q == ST_MUL)
		else $error("accepted beam did not enter the multiply step");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> st_q == ST_DIV_WAIT)
		else $error("divider finished outside the wait state");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free && !s_tready)
		else $error("result load while output register is occupied");

endmodule

// ----- rtl/lidar_sector_mean_distance.sv -----
// Each beam transfer is followed by an index-times-step multiply step, then an accumulate step,
// which can already take the next beam unless it ends the scan. A last beam is followed by
// three 16-bit serial divisions, one quotient bit a cycle on a shared divider, and no beam is
// taken until their result is loaded into the output register, which lets the next
// scan start while the result waits. Reset (arst_n, asynchronous, active low) clears the
// sums, counts, beam index and too-close flag and loads the register reset values.
module lidar_sector_mean_distance #(
	parameter int MAX_BEAMS = lsmd_pkg::MAX_BEAMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lsmd_pkg::RANGE_W-1:0]      s_tdata,   // range_mm
	input  logic                              s_tuser,   // no_return
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [3*lsmd_pkg::MEAN_W-1:0]     m_tdata,   // left_mean_mm, right_mean_mm, center_mean_mm
	output logic                              m_tuser,   // too_close
	input  logic                              cfg_we,
	input  logic [lsmd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [lsmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	lsmd_pkg::cmd_t cmd;
	lsmd_pkg::sts_t sts;

	lsmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsmd_dp #(
		.MAX_BEAMS(MAX_BEAMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for lidar_sector_mean_distance: beam streams in, sector means out.
// Predicts each scan result from its own sector sums and counts and checks every output
// transfer. Depends on lsmd_pkg and the block RTL.
module tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS  = 85;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [lsmd_pkg::RANGE_W-1:0] range_mm;
		logic                         no_return;
		logic                         last_beam;
	} beam_t;

	typedef struct packed {
		logic [lsmd_pkg::MEAN_W-1:0] left_mm;
		logic [lsmd_pkg::MEAN_W-1:0] right_mm;
		logic [lsmd_pkg::MEAN_W-1:0] center_mm;
		logic                        too_close;
	} means_t;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               s_tvalid  = 1'b0;
	logic                               s_tready;
	logic [lsmd_pkg::RANGE_W-1:0]       s_tdata   = '0;   // range_mm
	logic                               s_tuser   = 1'b0; // no_return
	logic                               s_tlast   = 1'b0;
	logic                               m_tvalid;
	logic                               m_tready  = 1'b0;
	logic [3*lsmd_pkg::MEAN_W-1:0]      m_tdata;   // left_mean_mm, right_mean_mm, center_mean_mm
	logic                               m_tuser;   // too_close
	logic                               cfg_we    = 1'b0;
	lsmd_pkg::cfg_idx_t                 cfg_idx   = lsmd_pkg::REG_START;
	logic [lsmd_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

	// predictor state and its copy of the registers
	int                                 cfg_start = -18000;
	int                                 cfg_step  = 100;
	logic [lsmd_pkg::RANGE_W-1:0]       cfg_stop  = 16'd1500;
	logic [lsmd_pkg::MEAN_W-1:0]        cfg_dflt  = 16'd15000;
	int                                 beam_idx  = 0;
	int unsigned                        sec_sum[3];
	int unsigned                        sec_cnt[3];
	logic                               close_seen = 1'b0;

	beam_t                              beams_to_send[$];
	means_t                             pending_means[$];
	beam_t                              next_beam;
	int                                 items_queued = 0;
	int                                 items_taken  = 0;
	int                                 mismatches   = 0;
	int                                 src_idle_pct = 0;
	int                                 rx_stall_pct = 0;
	logic                               hold_go      = 1'b0;
	int                                 hold_left    = 0;
	int unsigned                        cycle_cnt    = 0;

	lidar_sector_mean_distance u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic lsmd_pkg::sector_t sector_of(input int ang);
		if (ang > -lsmd_pkg::CENTER_LIM && ang < lsmd_pkg::CENTER_LIM)
			return lsmd_pkg::SEC_CENTER;
		if (ang > lsmd_pkg::CENTER_LIM && ang < lsmd_pkg::SIDE_LIM)
			return lsmd_pkg::SEC_RIGHT;
		if (ang < -lsmd_pkg::CENTER_LIM && ang > -lsmd_pkg::SIDE_LIM)
			return lsmd_pkg::SEC_LEFT;
		return lsmd_pkg::SEC_NONE;
	endfunction

	function automatic logic [lsmd_pkg::MEAN_W-1:0] mean_of(input lsmd_pkg::sector_t sec);
		if (sec_cnt[int'(sec)] == 0)
			return cfg_dflt;
		return lsmd_pkg::MEAN_W'(sec_sum[int'(sec)] / sec_cnt[int'(sec)]);
	endfunction

	function automatic void accumulate_beam(input logic [lsmd_pkg::RANGE_W-1:0] rng,
			input logic no_ret, input logic last);
		lsmd_pkg::sector_t sec;
		means_t            res;
		// beams past the limit are dropped; the index stays saturated
		if (beam_idx < lsmd_pkg::MAX_BEAMS_DEF) begin
			if (!no_ret) begin
				sec = sector_of(cfg_start + beam_idx * cfg_step);
				if (rng < cfg_stop)
					close_seen = 1'b1;
				if (sec != lsmd_pkg::SEC_NONE) begin
					sec_sum[int'(sec)] += rng;
					sec_cnt[int'(sec)] += 1;
				end
			end
			beam_idx++;
		end
		if (last) begin
			res.left_mm   = mean_of(lsmd_pkg::SEC_LEFT);
			res.right_mm  = mean_of(lsmd_pkg::SEC_RIGHT);
			res.center_mm = mean_of(lsmd_pkg::SEC_CENTER);
			res.too_close = close_seen;
			pending_means = {pending_means, res};
			beam_idx = 0;
			for (int s = 0; s < 3; s++) begin
				sec_sum[s] = 0;
				sec_cnt[s] = 0;
			end
		end
	endfunction

	function automatic void report(input string field, input int unsigned exp_v,
			input int unsigned act_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
		mismatches++;
	endfunction

	function automatic void check_means();
		means_t exp_m;
		if (pending_means.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h/%b", $time, m_tdata,
				m_tuser);
			mismatches++;
			return;
		end
		exp_m = pending_means.pop_front();
		if (m_tdata[lsmd_pkg::MEAN_W-1:0] !== exp_m.left_mm)
			report("left_mean_mm", exp_m.left_mm, m_tdata[lsmd_pkg::MEAN_W-1:0]);
		if (m_tdata[2*lsmd_pkg::MEAN_W-1:lsmd_pkg::MEAN_W] !== exp_m.right_mm)
			report("right_mean_mm", exp_m.right_mm,
				m_tdata[2*lsmd_pkg::MEAN_W-1:lsmd_pkg::MEAN_W]);
		if (m_tdata[3*lsmd_pkg::MEAN_W-1:2*lsmd_pkg::MEAN_W] !== exp_m.center_mm)
			report("center_mean_mm", exp_m.center_mm,
				m_tdata[3*lsmd_pkg::MEAN_W-1:2*lsmd_pkg::MEAN_W]);
		if (m_tuser !== exp_m.too_close)
			report("too_close", exp_m.too_close, m_tuser);
	endfunction

	// beam sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				accumulate_beam(s_tdata, s_tuser, s_tlast);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (beams_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_beam = beams_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_beam.range_mm;
					s_tuser  <= next_beam.no_return;
					s_tlast  <= next_beam.last_beam;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_means();
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic push_beam(input logic [lsmd_pkg::RANGE_W-1:0] rng, input logic no_ret,
			input logic last);
		beam_t b;
		b.range_mm  = rng;
		b.no_return = no_ret;
		b.last_beam = last;
		beams_to_send = {beams_to_send, b};
		items_queued++;
	endtask

	function automatic logic [lsmd_pkg::RANGE_W-1:0] pick_range();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return lsmd_pkg::RANGE_W'($urandom);
		endcase
	endfunction

	task automatic push_scan(input int len, input bit closed);
		for (int i = 0; i < len; i++)
			push_beam(pick_range(), $urandom_range(7) == 0, closed && i == len - 1);
	endtask

	task automatic write_reg(input lsmd_pkg::cfg_idx_t idx,
			input logic [lsmd_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			lsmd_pkg::REG_START: cfg_start = int'($signed(val));
			lsmd_pkg::REG_STEP:  cfg_step  = int'(val[lsmd_pkg::STEP_W-1:0]);
			lsmd_pkg::REG_STOP:  cfg_stop  = val;
			lsmd_pkg::REG_DFLT:  cfg_dflt  = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int start_cd, input int step_cd, input int stop_mm,
			input int dflt_mm);
		write_reg(lsmd_pkg::REG_START, start_cd[lsmd_pkg::CFG_DATA_W-1:0]);
		write_reg(lsmd_pkg::REG_STEP, step_cd[lsmd_pkg::CFG_DATA_W-1:0]);
		write_reg(lsmd_pkg::REG_STOP, stop_mm[lsmd_pkg::CFG_DATA_W-1:0]);
		write_reg(lsmd_pkg::REG_DFLT, dflt_mm[lsmd_pkg::CFG_DATA_W-1:0]);
	endtask

	// all beams taken, all results seen, then time for a beam still in the pipe
	task automatic drain();
		while (items_taken != items_queued)
			@(posedge clk);
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(input int src_pct, input int rx_pct);
		src_idle_pct = src_pct;
		rx_stall_pct = rx_pct;
	endtask

	initial begin
		int n;
		int len;
		int start_cd;
		int step_cd;
		int stop_mm;
		int dflt_mm;

		for (int s = 0; s < 3; s++) begin
			sec_sum[s] = 0;
			sec_cnt[s] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset register values; all beams far behind, stop distance not reached
		set_idle(0, 0);
		push_beam(16'hFFFF, 1'b0, 1'b0);
		push_beam(16'd1500, 1'b0, 1'b0);
		push_beam(16'd40000, 1'b0, 1'b1);
		push_beam(16'd2000, 1'b0, 1'b1);
		push_beam(16'd3000, 1'b0, 1'b0);
		push_beam(16'd3000, 1'b1, 1'b0);
		drain();

		// sector edges on whole beams; scan left open above carries on under the new angles
		set_config(-6000, 1500, 0, 0);
		push_beam(16'd100, 1'b0, 1'b0);
		push_beam(16'hFFFF, 1'b0, 1'b0);
		push_beam(16'd0, 1'b0, 1'b0);
		push_beam(16'd7, 1'b0, 1'b1);
		push_beam(16'hFFFF, 1'b0, 1'b0);
		push_beam(16'hFFFF, 1'b0, 1'b0);
		push_beam(16'hFFFE, 1'b0, 1'b0);
		push_beam(16'd1, 1'b0, 1'b0);
		push_beam(16'hFFFF, 1'b0, 1'b0);
		push_beam(16'd2, 1'b0, 1'b0);
		push_beam(16'd0, 1'b0, 1'b0);
		push_beam(16'd9, 1'b0, 1'b0);
		push_beam(16'd3, 1'b0, 1'b0);
		push_beam(16'd4, 1'b1, 1'b1);
		push_beam(16'd5, 1'b1, 1'b1);
		drain();

		// over-long scan: beams past the limit are short but must not raise too-close
		set_idle(23, 23);
		set_config(-6000, 10, 1000, $urandom_range(0, 65535));
		for (int i = 0; i < lsmd_pkg::MAX_BEAMS_DEF + 16; i++) begin
			if (i < lsmd_pkg::MAX_BEAMS_DEF)
				push_beam(lsmd_pkg::RANGE_W'($urandom_range(50000, 65535)),
					$urandom_range(15) == 0, 1'b0);
			else
				push_beam(lsmd_pkg::RANGE_W'($urandom_range(0, 999)), 1'b0,
					i == lsmd_pkg::MAX_BEAMS_DEF + 15);
		end
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: set_idle(0, 0);
				1: set_idle(74, 0);
				2: set_idle(0, 74);
				default: set_idle(23, 23);
			endcase
			if (p == 1)
				start_cd = -18000;
			else if (p == 2)
				start_cd = 18000;
			else if (p >= 5)
				start_cd = 100 * $urandom_range(0, 100) - 8000;
			else
				start_cd = $urandom_range(0, 10000) - 8000;
			if (p == 1)
				step_cd = 3600;
			else if (p == 2 || p == 6)
				step_cd = 0;
			else if (p == 3)
				step_cd = 1;
			else if (p >= 5)
				step_cd = 100 * $urandom_range(1, 20);
			else
				step_cd = $urandom_range(100, 2000);
			// too-close is sticky for the rest of the run, so it is held off until phase 4
			if (p < 4)
				stop_mm = 0;
			else if (p == 4)
				stop_mm = 65535;
			else
				stop_mm = $urandom_range(0, 65535);
			if (p == 0)
				dflt_mm = 0;
			else if (p == 1)
				dflt_mm = 65535;
			else
				dflt_mm = $urandom_range(0, 65535);
			set_config(start_cd, step_cd, stop_mm, dflt_mm);

			if (p == 0) begin
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
				// odd phases end mid-scan so the next settings apply part-way through it
				push_scan(len, !(n + len >= PHASE_ITEMS && p % 2 == 1));
				n += len;
			end
			drain();
		end

		push_beam(pick_range(), 1'b0, 1'b1);
		drain();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lsmd_pkg.sv
rtl/lsmd_div.sv
rtl/lsmd_dp.sv
rtl/lsmd_ctrl.sv
rtl/lidar_sector_mean_distance.sv
bench/tb.sv
